// ===== hw/rtl/lwpm_pkg.sv =====
// Shared constants and types for the lattice walk pivot move core.
`timescale 1ns / 1ps

package lwpm_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned LEN_BITS = 7;
  localparam logic [LEN_BITS-1:0] WALK_LEN_RESET = 7'd64;
  localparam int unsigned MIN_LEN = 2;

  localparam logic [1:0] ROT_90  = 2'd0;
  localparam logic [1:0] ROT_180 = 2'd1;
  localparam logic [1:0] ROT_270 = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PIVOT,
    ST_BUILD,
    ST_LOADI,
    ST_SCAN0,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } lwpm_state_e;

endpackage

// ===== hw/rtl/lattice_walk_pivot_move_core.sv =====
// Pivot move engine for a 2D square-lattice walk held in on-chip memories.
// Per item, with L the effective walk length: a pivot read, a build pass over L points,
// a pairwise repeat scan of each point i=1..L-1 against points 0..i-1, a copy-back of L
// points when accepted, and the result load; a repeat ends the scan early and skips the
// copy-back. One item at a time; the next is taken in idle, after the result is loaded.
// After reset a sweep writes the straight rod into all MAX_POINTS entries; no item before it ends.
`timescale 1ns / 1ps

module lattice_walk_pivot_move_core #(
  parameter int unsigned MAX_POINTS = lwpm_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = lwpm_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,      // walk_length
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pivot_index[5:0], side[6], rotation[8:7]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata     // accepted[0], check_count[7:1]
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned LB = lwpm_pkg::LEN_BITS;

  logic [PW-1:0] wmem [MAX_POINTS];
  logic [PW-1:0] cmem [MAX_POINTS];

  lwpm_pkg::lwpm_state_e state_q, state_d;

  logic [LB-1:0] walk_len_q;
  logic [CW-1:0] len_q, len_d, len_eff;
  logic [IW-1:0] piv_q, piv_d, piv_sat;
  logic          side_q, side_d;
  logic [1:0]    rot_q, rot_d;
  logic [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [PW-1:0] pi_q, pi_d;
  logic [IW-1:0] idx_q, idx_d, jdx_q, jdx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d, out_acc_q, out_acc_d;
  logic [6:0]    out_cnt_q, out_cnt_d;
  logic          res_acc_q, res_acc_d;
  logic [6:0]    res_cnt_q, res_cnt_d;

  logic          wmem_we, cmem_we;
  logic [IW-1:0] wmem_waddr, wmem_raddr, cmem_waddr, cmem_raddr;
  logic [PW-1:0] wmem_wdata, cmem_wdata, wmem_rdata_q, cmem_rdata_q;

  logic          in_fire, out_fire;
  logic [5:0]    in_piv;
  logic          in_side;
  logic [1:0]    in_rot;
  logic          last_build, last_scan_j, last_i, hit, out_free;
  logic [COORD_BITS-1:0] px, py, dx, dy, tx, ty;

  assign in_piv  = s_axis_tdata[5:0];
  assign in_side = s_axis_tdata[6];
  assign in_rot  = s_axis_tdata[8:7];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == lwpm_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cnt_q, out_acc_q};
  assign out_fire      = out_valid_q & m_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Saturate the configured length and the pivot.
  always_comb begin
    if (32'(walk_len_q) < lwpm_pkg::MIN_LEN) begin
      len_eff = CW'(lwpm_pkg::MIN_LEN);
    end else if (32'(walk_len_q) > MAX_POINTS) begin
      len_eff = CW'(MAX_POINTS);
    end else begin
      len_eff = CW'(walk_len_q);
    end
    if (32'(in_piv) >= 32'(len_eff)) begin
      piv_sat = IW'(len_eff - CW'(1));
    end else begin
      piv_sat = IW'(in_piv);
    end
  end

  // Transform of the walk point read during the build pass.
  always_comb begin
    px = wmem_rdata_q[COORD_BITS-1:0];
    py = wmem_rdata_q[PW-1:COORD_BITS];
    dx = px - cx_q;
    dy = py - cy_q;
    case (rot_q)
      lwpm_pkg::ROT_90: begin
        tx = dy;
        ty = -dx;
      end
      lwpm_pkg::ROT_180: begin
        tx = -dx;
        ty = -dy;
      end
      lwpm_pkg::ROT_270: begin
        tx = -dy;
        ty = dx;
      end
      default: begin
        tx = dx;
        ty = dy;
      end
    endcase
  end

  assign last_build  = (CW'(idx_q) == len_q - CW'(1));
  assign last_i      = (CW'(idx_q) == len_q - CW'(1));
  assign last_scan_j = (jdx_q == idx_q - IW'(1));
  assign hit         = (cmem_rdata_q == pi_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lwpm_pkg::ST_INIT:   if (idx_q == IW'(MAX_POINTS - 1)) state_d = lwpm_pkg::ST_IDLE;
      lwpm_pkg::ST_IDLE:   if (in_fire) state_d = lwpm_pkg::ST_PIVOT;
      lwpm_pkg::ST_PIVOT:  state_d = lwpm_pkg::ST_BUILD;
      lwpm_pkg::ST_BUILD:  if (last_build) state_d = lwpm_pkg::ST_LOADI;
      lwpm_pkg::ST_LOADI:  state_d = lwpm_pkg::ST_SCAN0;
      lwpm_pkg::ST_SCAN0:  state_d = lwpm_pkg::ST_SCAN;
      lwpm_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = lwpm_pkg::ST_DONE;
        end else if (last_scan_j) begin
          state_d = last_i ? lwpm_pkg::ST_COMMIT : lwpm_pkg::ST_LOADI;
        end
      end
      lwpm_pkg::ST_COMMIT: if (cnt_q == len_q) state_d = lwpm_pkg::ST_DONE;
      lwpm_pkg::ST_DONE:   if (out_free) state_d = lwpm_pkg::ST_IDLE;
      default:             state_d = lwpm_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    len_d       = len_q;
    piv_d       = piv_q;
    side_d      = side_q;
    rot_d       = rot_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    pi_d        = pi_q;
    idx_d       = idx_q;
    jdx_d       = jdx_q;
    cnt_d       = cnt_q;
    res_acc_d   = res_acc_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    out_acc_d   = out_acc_q;
    out_cnt_d   = out_cnt_q;
    wmem_we     = 1'b0;
    wmem_waddr  = idx_q;
    wmem_wdata  = '0;
    wmem_raddr  = idx_q;
    cmem_we     = 1'b0;
    cmem_waddr  = idx_q;
    cmem_wdata  = '0;
    cmem_raddr  = idx_q;
    case (state_q)
      lwpm_pkg::ST_INIT: begin
        wmem_we    = 1'b1;
        wmem_wdata = {COORD_BITS'(idx_q), COORD_BITS'(0)};
        idx_d      = idx_q + IW'(1);
        if (idx_q == IW'(MAX_POINTS - 1)) idx_d = '0;
      end
      lwpm_pkg::ST_IDLE: begin
        wmem_raddr = piv_sat;
        if (in_fire) begin
          len_d  = len_eff;
          piv_d  = piv_sat;
          side_d = in_side;
          rot_d  = in_rot;
        end
      end
      lwpm_pkg::ST_PIVOT: begin
        cx_d       = wmem_rdata_q[COORD_BITS-1:0];
        cy_d       = wmem_rdata_q[PW-1:COORD_BITS];
        wmem_raddr = '0;
        idx_d      = '0;
      end
      lwpm_pkg::ST_BUILD: begin
        cmem_we    = 1'b1;
        cmem_waddr = idx_q;
        if (side_q ? (idx_q >= piv_q) : (idx_q < piv_q)) begin
          cmem_wdata = {ty + cy_q, tx + cx_q};
        end else begin
          cmem_wdata = wmem_rdata_q;
        end
        wmem_raddr = idx_q + IW'(1);
        idx_d      = last_build ? IW'(1) : idx_q + IW'(1);
      end
      lwpm_pkg::ST_LOADI: begin
        cmem_raddr = idx_q;
      end
      lwpm_pkg::ST_SCAN0: begin
        pi_d       = cmem_rdata_q;
        cmem_raddr = '0;
        jdx_d      = '0;
      end
      lwpm_pkg::ST_SCAN: begin
        cmem_raddr = jdx_q + IW'(1);
        jdx_d      = jdx_q + IW'(1);
        if (hit) begin
          res_acc_d = 1'b0;
          res_cnt_d = 7'(CW'(idx_q) + CW'(1));
        end else if (last_scan_j) begin
          idx_d = idx_q + IW'(1);
          cnt_d = '0;
          res_acc_d = 1'b1;
          res_cnt_d = 7'(len_q);
        end
      end
      lwpm_pkg::ST_COMMIT: begin
        // Read candidate k, write it back to the walk in the following cycle.
        cmem_raddr = cnt_q[IW-1:0];
        wmem_we    = (cnt_q != '0);
        wmem_waddr = IW'(cnt_q - CW'(1));
        wmem_wdata = cmem_rdata_q;
        cnt_d      = cnt_q + CW'(1);
      end
      lwpm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_acc_d   = res_acc_q;
          out_cnt_d   = res_cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wmem_we) begin
      wmem[wmem_waddr] <= wmem_wdata;
    end
    wmem_rdata_q <= wmem[wmem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmem_we) begin
      cmem[cmem_waddr] <= cmem_wdata;
    end
    cmem_rdata_q <= cmem[cmem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwpm_pkg::ST_INIT;
      walk_len_q  <= lwpm_pkg::WALK_LEN_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        walk_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    piv_q     <= piv_d;
    side_q    <= side_d;
    rot_q     <= rot_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    pi_q      <= pi_d;
    jdx_q     <= jdx_d;
    cnt_q     <= cnt_d;
    res_acc_q <= res_acc_d;
    res_cnt_q <= res_cnt_d;
    out_acc_q <= out_acc_d;
    out_cnt_q <= out_cnt_d;
  end

endmodule

// ===== sim/tb_lattice_walk_pivot_move_core.sv =====
// Self-checking testbench for the lattice walk pivot move core.
`timescale 1ns / 1ps

module tb_lattice_walk_pivot_move_core;

  localparam int unsigned NPTS = 64;
  localparam int unsigned CBITS = 16;

  typedef logic [CBITS-1:0] coord_t;
  typedef struct packed {
    logic [6:0] check_count;
    logic       accepted;
  } move_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  lattice_walk_pivot_move_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Shadow walk and length
  coord_t       walk_x [NPTS];
  coord_t       walk_y [NPTS];
  logic [6:0]   len_reg;
  move_result_t pending_moves[$];
  int           n_errors;
  int           n_results;
  int           n_accepts;
  int           n_items;
  bit           idle_on = 1'b1;
  int           hold_cycles = 0;
  int           rx_idle = 0;

  function automatic coord_t neg(coord_t v);
    return coord_t'(0) - v;
  endfunction

  function automatic move_result_t predict_move(logic [5:0] piv_in, logic side,
                                                logic [1:0] rot);
    coord_t     cx [NPTS];
    coord_t     cy [NPTS];
    coord_t     ox, oy, dx, dy, tx, ty;
    int         len, piv, cnt;
    bit         clash;
    move_result_t r;
    len = len_reg;
    if (len < lwpm_pkg::MIN_LEN) len = lwpm_pkg::MIN_LEN;
    if (len > NPTS) len = NPTS;
    piv = piv_in;
    if (piv >= len) piv = len - 1;
    ox = walk_x[piv];
    oy = walk_y[piv];
    for (int i = 0; i < len; i++) begin
      cx[i] = walk_x[i];
      cy[i] = walk_y[i];
      if (side ? (i >= piv) : (i < piv)) begin
        dx = cx[i] - ox;
        dy = cy[i] - oy;
        case (rot)
          lwpm_pkg::ROT_90:  begin tx = dy;      ty = neg(dx); end
          lwpm_pkg::ROT_180: begin tx = neg(dx); ty = neg(dy); end
          lwpm_pkg::ROT_270: begin tx = neg(dy); ty = dx;      end
          default: begin tx = dx;      ty = dy;      end
        endcase
        cx[i] = tx + ox;
        cy[i] = ty + oy;
      end
    end
    clash = 1'b0;
    cnt = len;
    for (int i = 1; i < len && !clash; i++)
      for (int j = 0; j < i; j++)
        if (!clash && cx[j] == cx[i] && cy[j] == cy[i]) begin
          clash = 1'b1;
          cnt = i + 1;
        end
    if (!clash)
      for (int i = 0; i < len; i++) begin
        walk_x[i] = cx[i];
        walk_y[i] = cy[i];
      end
    r.accepted = !clash;
    r.check_count = cnt[6:0];
    return r;
  endfunction

  task automatic random_gap();
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
  endtask

  task automatic send_move(logic [5:0] piv, logic side, logic [1:0] rot);
    random_gap();
    s_axis_tdata = {7'd0, rot, side, piv};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_moves = {pending_moves, predict_move(piv, side, rot)};
    n_items++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Hold off until all results are in, then write the length register
  task automatic set_length(logic [6:0] value);
    while (pending_moves.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    len_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stall bursts, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle = rx_idle - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_idle = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    move_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      n_results++;
      if (pending_moves.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_moves.pop_front();
        if (got.accepted) n_accepts++;
        if (got.accepted !== want.accepted || got.check_count !== want.check_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: accepted exp %0d got %0d, count exp %0d got %0d",
                     want.accepted, got.accepted, want.check_count, got.check_count);
        end
      end
    end
  end

  task automatic test_directed();
    // Every side and rotation, including the identity code, at pivots 1 and 63
    for (int r = 0; r < 4; r++) begin
      send_move(6'd1, r[0], r[1:0]);
      send_move(6'd63, ~r[0], r[1:0]);
    end
    send_move(6'd0, 1'b0, lwpm_pkg::ROT_90);
    send_move(6'd0, 1'b1, lwpm_pkg::ROT_180);
    send_move(6'd32, 1'b1, lwpm_pkg::ROT_270);
    set_length(7'd2);
    send_move(6'd1, 1'b0, lwpm_pkg::ROT_90);
    send_move(6'd63, 1'b1, lwpm_pkg::ROT_180);
    set_length(7'd0);
    send_move(6'd1, 1'b1, lwpm_pkg::ROT_270);
    set_length(7'd127);
    send_move(6'd40, 1'b0, lwpm_pkg::ROT_180);
    send_move(6'd20, 1'b1, 2'd3);
  endtask

  task automatic test_random_moves(int count, int max_len);
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) set_length(7'($urandom_range(lwpm_pkg::MIN_LEN, max_len)));
      send_move(6'($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                            : $urandom_range(1, len_reg - 1)),
                1'($urandom), $urandom_range(0, 9) == 0 ? 2'd3
                                                       : 2'($urandom_range(0, 2)));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 2000;
    for (int n = 0; n < 6; n++) send_move(6'($urandom_range(0, 63)), 1'($urandom),
                                          2'($urandom));
  endtask

  initial begin
    n_errors = 0; n_results = 0; n_accepts = 0; n_items = 0;
    for (int k = 0; k < NPTS; k++) begin
      walk_x[k] = '0;
      walk_y[k] = coord_t'(k);
    end
    len_reg = lwpm_pkg::WALK_LEN_RESET;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_moves(1200, 16);
    test_backpressure();
    test_random_moves(450, 64);
    idle_on = 1'b0;
    test_random_moves(250, 64);
    while (pending_moves.size() != 0) @(negedge clk_i);
    repeat (3000) @(negedge clk_i);
    if (pending_moves.size() != 0) n_errors++;
    $display("Sent %0d pivot moves over several walk lengths; %0d results, %0d accepted.",
             n_items, n_results, n_accepts);
    if (n_errors == 0) $display("[lattice_walk_pivot_move_core] OK");
    else $display("[lattice_walk_pivot_move_core] ERROR");
    $finish;
  end

  initial begin
    #400ms;
    $display("[lattice_walk_pivot_move_core] ERROR");
    $finish;
  end

endmodule
